// ===== src/mcma_pkg.sv =====
// Shared constants, field layout and controller/datapath interface types.
package mcma_pkg;

    // Block configuration
    localparam int CHANNELS    = 4;
    localparam int WINDOW      = 8;
    localparam int SAMPLE_BITS = 12;

    // Stream field widths
    localparam int CHAN_W   = 2;
    localparam int SAMPLE_W = 12;
    localparam int TDATA_W  = 16;
    localparam int TUSER_W  = 1;

    // Derived sizes
    localparam int CH_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_BITS  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int DEPTH     = CHANNELS * WINDOW;
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_BITS  = $clog2(WINDOW * ((1 << SAMPLE_BITS) - 1) + 1);

    // Reciprocal of WINDOW scaled by 2^SUM_BITS, rounded down
    localparam int RECIP_BITS = SUM_BITS + 1;
    localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;
    localparam logic [RECIP_BITS-1:0] RECIP =
        RECIP_BITS'((64'd1 << SUM_BITS) / WINDOW);

    // Item kinds carried in tuser
    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;        // capture the incoming transfer
        logic restart;     // clear position and primed flag
        logic drop;        // out-of-range channel: only honour frame end
        logic fill_write;  // write one priming entry
        logic fill_done;   // last priming entry: set sum and result
        logic rd;          // read the oldest entry
        logic upd;         // replace entry and update running sum
        logic mul;         // multiply sum by reciprocal
        logic quo;         // correct quotient into result
        logic emit;        // load output register, advance frame
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic restart_in;  // incoming transfer is a restart
        logic chan_ok_in;  // incoming channel is in range
        logic primed;
        logic fill_last;   // priming counter at last entry
        logic out_free;    // output register can take a result
    } status_t;

endpackage

// ===== src/mcma_ram.sv =====
// Generic single-port RAM with registered read data.
module mcma_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read on one port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/mcma_datapath.sv =====
// Datapath: window store, running sums, divider by the window length and output register.
module mcma_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  mcma_pkg::cmd_t                  cmd,
    output mcma_pkg::status_t               status,
    input  logic [mcma_pkg::TDATA_W-1:0]    s_tdata,   // channel, sample
    input  logic [mcma_pkg::TUSER_W-1:0]    s_tuser,   // kind
    input  logic                            s_tlast,   // frame_end
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mcma_pkg::TDATA_W-1:0]    m_tdata    // out_channel, average
);

    // Captured item
    logic [mcma_pkg::CH_BITS-1:0]     ch_reg;
    logic [mcma_pkg::SAMPLE_BITS-1:0] smp_reg;
    logic                             fend_reg;

    // Frame state
    logic [mcma_pkg::POS_BITS-1:0]    pos_reg;
    logic                             primed_reg;
    logic [mcma_pkg::POS_BITS-1:0]    fill_cnt_reg;

    // Sums and per-entry valid bits
    logic [mcma_pkg::SUM_BITS-1:0]    sums_reg [mcma_pkg::CHANNELS];
    logic                             valid_reg [mcma_pkg::DEPTH];
    logic                             old_valid_reg;

    // Arithmetic pipeline
    logic [mcma_pkg::SUM_BITS-1:0]    acc_reg;
    logic [mcma_pkg::PROD_BITS-1:0]   prod_reg;
    logic [mcma_pkg::SAMPLE_BITS-1:0] result_reg;

    // Output register
    logic                             m_tvalid_reg;
    logic [mcma_pkg::CHAN_W-1:0]      m_chan_reg;
    logic [mcma_pkg::SAMPLE_W-1:0]    m_avg_reg;

    // Input field decode
    logic [mcma_pkg::CHAN_W-1:0]      in_chan;
    logic [15:0]                      in_chan_wide;
    logic [15:0]                      in_smp_wide;
    logic [mcma_pkg::CH_BITS-1:0]     in_ch_idx;
    logic [mcma_pkg::SAMPLE_BITS-1:0] in_smp;

    assign in_chan      = s_tdata[mcma_pkg::CHAN_W-1:0];
    assign in_chan_wide = 16'(in_chan);
    assign in_ch_idx    = in_chan_wide[mcma_pkg::CH_BITS-1:0];
    assign in_smp_wide  = 16'(s_tdata[mcma_pkg::CHAN_W +: mcma_pkg::SAMPLE_W]);
    assign in_smp       = in_smp_wide[mcma_pkg::SAMPLE_BITS-1:0];

    // Memory address: row of the channel, column of fill counter or position
    logic [mcma_pkg::POS_BITS-1:0]    col;
    logic [mcma_pkg::ADDR_BITS-1:0]   addr;
    logic                             ram_we;
    logic [mcma_pkg::SAMPLE_BITS-1:0] ram_rdata;

    assign col    = cmd.fill_write ? fill_cnt_reg : pos_reg;
    assign addr   = mcma_pkg::ADDR_BITS'(32'(ch_reg) * 32'(mcma_pkg::WINDOW) + 32'(col));
    assign ram_we = cmd.fill_write | cmd.upd;

    mcma_ram #(
        .WIDTH (mcma_pkg::SAMPLE_BITS),
        .DEPTH (mcma_pkg::DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (cmd.rd),
        .addr  (addr),
        .wdata (smp_reg),
        .rdata (ram_rdata)
    );

    // Running sum update: drop oldest entry, add new sample
    logic [mcma_pkg::SAMPLE_BITS-1:0] old_smp;
    logic [mcma_pkg::SUM_BITS-1:0]    new_sum;

    assign old_smp = old_valid_reg ? ram_rdata : '0;
    assign new_sum = sums_reg[ch_reg] - mcma_pkg::SUM_BITS'(old_smp)
                   + mcma_pkg::SUM_BITS'(smp_reg);

    // Quotient estimate is at most one short; fix with one compare
    logic [mcma_pkg::SUM_BITS-1:0]    q_est;
    logic [mcma_pkg::SUM_BITS-1:0]    rem;
    logic [mcma_pkg::SUM_BITS-1:0]    q_fix;

    assign q_est = prod_reg[mcma_pkg::SUM_BITS +: mcma_pkg::SUM_BITS];
    assign rem   = acc_reg - mcma_pkg::SUM_BITS'(32'(q_est) * 32'(mcma_pkg::WINDOW));
    assign q_fix = (rem >= mcma_pkg::SUM_BITS'(mcma_pkg::WINDOW)) ? q_est + 1'b1 : q_est;

    // Frame advance on a frame end, from a dropped transfer or from a finished sample
    logic adv;
    assign adv = (cmd.drop & s_tlast) | (cmd.emit & fend_reg);

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            primed_reg   <= 1'b0;
            fill_cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
            for (int c = 0; c < mcma_pkg::CHANNELS; c++) begin
                sums_reg[c] <= '0;
            end
            for (int i = 0; i < mcma_pkg::DEPTH; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            // Position and primed flag
            if (cmd.restart) begin
                pos_reg    <= '0;
                primed_reg <= 1'b0;
            end else if (adv) begin
                if (!primed_reg) begin
                    primed_reg <= 1'b1;
                    pos_reg    <= '0;
                end else if (pos_reg == mcma_pkg::POS_BITS'(mcma_pkg::WINDOW - 1)) begin
                    pos_reg <= '0;
                end else begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end

            // Priming sweep counter
            if (cmd.load) begin
                fill_cnt_reg <= '0;
            end else if (cmd.fill_write) begin
                fill_cnt_reg <= fill_cnt_reg + 1'b1;
            end

            // Mark written entries
            if (ram_we) begin
                valid_reg[addr] <= 1'b1;
            end

            // Running sums
            if (cmd.fill_done) begin
                sums_reg[ch_reg] <= mcma_pkg::SUM_BITS'(32'(smp_reg) * 32'(mcma_pkg::WINDOW));
            end else if (cmd.upd) begin
                sums_reg[ch_reg] <= new_sum;
            end

            // Output valid: set on emit, clear when taken
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ch_reg   <= in_ch_idx;
            smp_reg  <= in_smp;
            fend_reg <= s_tlast;
        end
        if (cmd.rd) begin
            old_valid_reg <= valid_reg[addr];
        end
        if (cmd.upd) begin
            acc_reg <= new_sum;
        end
        if (cmd.mul) begin
            prod_reg <= mcma_pkg::PROD_BITS'(acc_reg) * mcma_pkg::PROD_BITS'(mcma_pkg::RECIP);
        end
        if (cmd.fill_done) begin
            result_reg <= smp_reg;
        end else if (cmd.quo) begin
            result_reg <= mcma_pkg::SAMPLE_BITS'(q_fix);
        end
        if (cmd.emit) begin
            m_chan_reg <= mcma_pkg::CHAN_W'(32'(ch_reg));
            m_avg_reg  <= mcma_pkg::SAMPLE_W'(32'(result_reg));
        end
    end

    // Status towards the controller
    assign status.restart_in = (s_tuser[0] == mcma_pkg::KIND_RESTART);
    assign status.chan_ok_in = (32'(in_chan) < 32'(mcma_pkg::CHANNELS));
    assign status.primed     = primed_reg;
    assign status.fill_last  = (fill_cnt_reg == mcma_pkg::POS_BITS'(mcma_pkg::WINDOW - 1));
    assign status.out_free   = ~m_tvalid_reg | m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = mcma_pkg::TDATA_W'({m_avg_reg, m_chan_reg});

endmodule

// ===== src/mcma_ctrl.sv =====
// Controller: sequences priming fills, read-modify-write and division per sample.
module mcma_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  mcma_pkg::status_t status,
    output mcma_pkg::cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_FILL = 7'b0000010,
        ST_READ = 7'b0000100,
        ST_UPD  = 7'b0001000,
        ST_MUL  = 7'b0010000,
        ST_QUO  = 7'b0100000,
        ST_EMIT = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load = 1'b1;
                    priority if (status.restart_in) begin
                        cmd.restart = 1'b1;
                    end else if (!status.chan_ok_in) begin
                        cmd.drop = 1'b1;
                    end else if (status.primed) begin
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_FILL;
                    end
                end
            end
            ST_FILL: begin
                cmd.fill_write = 1'b1;
                if (status.fill_last) begin
                    cmd.fill_done = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_READ: begin
                cmd.rd     = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                cmd.upd    = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_QUO;
            end
            ST_QUO: begin
                cmd.quo    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                // Hold until the output register is free
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/multichannel_moving_average_unit.sv =====
// A primed sample steps through read, update, multiply, quotient and emit; a priming
// sample through fill, one store write per cycle over the channel's window, and emit.
// New samples are taken only in idle: the single store port and multiply-then-correct
// divide serve one sample, and emit waits for a free output register. The output
// register takes a result while the next sample runs.
// Reset clears sums, position, primed flag and entry valid bits at once; no clearing pass.
module multichannel_moving_average_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mcma_pkg::TDATA_W-1:0]    s_tdata,   // [1:0] channel, [13:2] sample
    input  logic [mcma_pkg::TUSER_W-1:0]    s_tuser,   // [0] kind
    input  logic                            s_tlast,   // frame_end
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mcma_pkg::TDATA_W-1:0]    m_tdata    // [1:0] out_channel, [13:2] average
);

    mcma_pkg::cmd_t    cmd;
    mcma_pkg::status_t status;

    // Sequencer
    mcma_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Storage and arithmetic
    mcma_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== bench/multichannel_moving_average_checker.sv =====
`timescale 1ns / 1ps
// Checker for the moving average unit: watches both streams, predicts window means, compares.
module multichannel_moving_average_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [mcma_pkg::TDATA_W-1:0]    s_tdata,   // [1:0] channel, [13:2] sample
    input  logic [mcma_pkg::TUSER_W-1:0]    s_tuser,   // [0] kind
    input  logic                            s_tlast,   // frame_end
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [mcma_pkg::TDATA_W-1:0]    m_tdata,   // [1:0] out_channel, [13:2] average
    output int                              fault_count,
    output int                              pending_results
);
    import mcma_pkg::*;

    typedef struct packed {
        logic [CHAN_W-1:0]   chan;
        logic [SAMPLE_W-1:0] mean;
    } mean_result_t;

    // Shadow copy of the filter state
    logic [SAMPLE_W-1:0] ring [CHANNELS][WINDOW];
    logic [SUM_BITS-1:0] run_sum [CHANNELS];
    logic [POS_BITS-1:0] ring_pos;
    logic                is_primed;

    mean_result_t expected_means[$];

    // Close the frame: leave priming, or step the shared position round the ring
    task automatic close_frame();
        if (!is_primed) begin
            is_primed = 1'b1;
            ring_pos  = '0;
        end else if (ring_pos == POS_BITS'(WINDOW - 1)) begin
            ring_pos = '0;
        end else begin
            ring_pos = ring_pos + 1'b1;
        end
    endtask

    // Apply one accepted transfer to the shadow state and queue any mean it yields
    task automatic predict_mean(input logic kind, input logic [CHAN_W-1:0] chan,
                                input logic [SAMPLE_W-1:0] samp, input logic fend);
        mean_result_t res;
        int           k;
        if (kind == KIND_RESTART) begin
            ring_pos  = '0;
            is_primed = 1'b0;
        end else if (chan >= CHANNELS) begin
            if (fend)
                close_frame();
        end else begin
            res.chan = chan;
            if (!is_primed) begin
                // Priming: fill the whole window and echo the sample
                for (k = 0; k < WINDOW; k++)
                    ring[chan][k] = samp;
                run_sum[chan] = SUM_BITS'(samp * WINDOW);
                res.mean      = samp;
            end else begin
                // Replace the oldest entry and take the truncated mean
                run_sum[chan]        = run_sum[chan] - ring[chan][ring_pos] + samp;
                ring[chan][ring_pos] = samp;
                res.mean             = SAMPLE_W'(run_sum[chan] / WINDOW);
            end
            if (fend)
                close_frame();
            expected_means.push_back(res);
        end
    endtask

    // Compare results, then predict from inputs, once per clock edge
    always @(posedge aclk) begin : watch
        mean_result_t got;
        mean_result_t want;
        int           c;
        int           k;
        if (!aresetn) begin
            for (c = 0; c < CHANNELS; c++) begin
                run_sum[c] = '0;
                for (k = 0; k < WINDOW; k++)
                    ring[c][k] = '0;
            end
            ring_pos  = '0;
            is_primed = 1'b0;
            expected_means.delete();
            fault_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.chan = m_tdata[CHAN_W-1:0];
                got.mean = m_tdata[CHAN_W +: SAMPLE_W];
                if (expected_means.size() == 0) begin
                    $error("unexpected result transfer: out_channel %0d average %0d",
                           got.chan, got.mean);
                    fault_count++;
                end else begin
                    want = expected_means.pop_front();
                    if (got.chan !== want.chan) begin
                        $error("out_channel mismatch: expected %0d, actual %0d",
                               want.chan, got.chan);
                        fault_count++;
                    end
                    if (got.mean !== want.mean) begin
                        $error("average mismatch: expected %0d, actual %0d",
                               want.mean, got.mean);
                        fault_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_mean(s_tuser[0], s_tdata[CHAN_W-1:0],
                             s_tdata[CHAN_W +: SAMPLE_W], s_tlast);
        end
        pending_results = expected_means.size();
    end

endmodule

// ===== bench/tb_multichannel_moving_average_unit.sv =====
`timescale 1ns / 1ps
// Testbench top: clock, reset, sample stream stimulus with random idling, and the verdict.
module tb_multichannel_moving_average_unit;
    import mcma_pkg::*;

    localparam int DRAIN_CYCLES   = 4 * (WINDOW + 2);
    localparam int PHASE_ITEMS    = 366;
    localparam int RUN_LIMIT_NS   = 5_000_000;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic [TDATA_W-1:0] s_tdata  = '0;
    logic [TUSER_W-1:0] s_tuser  = '0;
    logic               s_tlast  = 1'b0;
    logic               m_tready = 1'b0;
    wire                s_tready;
    wire                m_tvalid;
    wire  [TDATA_W-1:0] m_tdata;

    int send_idle_pct = 17;
    int recv_idle_pct = 46;
    int fault_count;
    int pending_results;

    multichannel_moving_average_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    multichannel_moving_average_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fault_count     (fault_count),
        .pending_results (pending_results)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Stall the result channel at random
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Bias samples towards the rails now and then
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int pick;
        pick = $urandom_range(7);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return '1;
        else
            return SAMPLE_W'($urandom_range(4095));
    endfunction

    // Present one item, idling first at random, and hold it until the transfer
    task automatic send_item(input logic kind, input logic [CHAN_W-1:0] chan,
                             input logic [SAMPLE_W-1:0] samp, input logic fend);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(TDATA_W - CHAN_W - SAMPLE_W){1'b0}}, samp, chan};
        s_tuser  <= TUSER_W'(kind);
        s_tlast  <= fend;
        do
            @(posedge aclk);
        while (!s_tready);
    endtask

    // One well-formed frame: every channel once, frame end on the last
    task automatic send_frame();
        int c;
        for (c = 0; c < CHANNELS; c++)
            send_item(KIND_SAMPLE, CHAN_W'(c), pick_sample(), c == CHANNELS - 1);
    endtask

    // Mostly clean frames, some restarts, some stray samples
    task automatic run_random(input int quota);
        int sent;
        int pick;
        sent = 0;
        while (sent < quota) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                send_frame();
                sent += CHANNELS;
            end else if (pick < 86) begin
                send_item(KIND_RESTART, CHAN_W'($urandom_range(3)),
                          SAMPLE_W'($urandom_range(4095)), 1'($urandom_range(1)));
                sent++;
            end else begin
                send_item(KIND_SAMPLE, CHAN_W'($urandom_range(3)), pick_sample(),
                          1'($urandom_range(1)));
                sent++;
            end
        end
    endtask

    initial begin
        int k;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Priming frame with rail and alternating patterns
        send_item(KIND_SAMPLE, 2'd0, 12'h000, 1'b0);
        send_item(KIND_SAMPLE, 2'd1, 12'hFFF, 1'b0);
        send_item(KIND_SAMPLE, 2'd2, 12'hAAA, 1'b0);
        send_item(KIND_SAMPLE, 2'd3, 12'h555, 1'b1);
        // First primed frame, patterns swapped
        send_item(KIND_SAMPLE, 2'd0, 12'hFFF, 1'b0);
        send_item(KIND_SAMPLE, 2'd1, 12'h000, 1'b0);
        send_item(KIND_SAMPLE, 2'd2, 12'h555, 1'b0);
        send_item(KIND_SAMPLE, 2'd3, 12'hAAA, 1'b1);
        // Restart carrying a frame end that must be ignored
        send_item(KIND_RESTART, 2'd3, 12'hFFF, 1'b1);
        // Priming frame with a repeated channel and a missing one
        send_item(KIND_SAMPLE, 2'd0, 12'hFFF, 1'b0);
        send_item(KIND_SAMPLE, 2'd1, 12'h001, 1'b0);
        send_item(KIND_SAMPLE, 2'd1, 12'hFFF, 1'b0);
        send_item(KIND_SAMPLE, 2'd3, 12'h007, 1'b1);
        // Single-channel frames to carry the position past its wrap
        for (k = 0; k <= WINDOW; k++)
            send_item(KIND_SAMPLE, 2'd0, (k % 2 == 0) ? 12'hFFF : 12'h123, 1'b1);

        run_random(PHASE_ITEMS);
        send_idle_pct = 46;
        recv_idle_pct = 17;
        run_random(PHASE_ITEMS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(PHASE_ITEMS);
        s_tvalid <= 1'b0;

        // Drain outstanding results, then allow for stray late transfers
        do
            @(negedge aclk);
        while (pending_results != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fault_count == 0 && pending_results == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Abandon a hung run
    initial begin
        #(RUN_LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
src/mcma_pkg.sv
src/mcma_ram.sv
src/mcma_datapath.sv
src/mcma_ctrl.sv
src/multichannel_moving_average_unit.sv
bench/multichannel_moving_average_checker.sv
bench/tb_multichannel_moving_average_unit.sv
